>>> rtl/ckf_pkg.sv
`timescale 1ns / 1ps

package ckf_pkg;

    // Longest pattern the comparators are built for; the window holds one byte less.
    localparam int unsigned MAX_PATTERN_LEN = 15;
    localparam int unsigned WIN_LEN         = MAX_PATTERN_LEN - 1;
    localparam int unsigned LANG_W          = 32;

    // Default depths of the byte request queue and the verdict queue.
    localparam int unsigned MID_QUEUE_DEPTH = 2;
    localparam int unsigned OUT_QUEUE_DEPTH = 2;

    typedef logic [7:0]                     t_byte;
    typedef logic [8*MAX_PATTERN_LEN-1:0]   t_pat_text;
    typedef logic [8*WIN_LEN-1:0]           t_window;

    // Classified request from the front end to the matcher.
    typedef struct packed {
        t_byte              ch;
        logic               keep;
        logic               last;
        logic               priv;
        logic [LANG_W-1:0]  lang;
    } t_mid_item;

    // Verdict handed from the matcher to the result queue.
    typedef struct packed {
        logic push;
        logic blocked;
    } t_verdict;

    // Whitespace and control bytes, the upper-case letter range and the case bit.
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_UP_A  = 8'h41;
    localparam t_byte CH_UP_Z  = 8'h5A;
    localparam t_byte CASE_BIT = 8'h20;

    // Pattern table, right aligned so the last character sits in the low byte.
    // Every listed pattern that contains "wow" is already covered by the plain
    // "wow" entry, since the hit flag is sticky for the whole message, and
    // duplicate entries add nothing; those are therefore not built.
    localparam int unsigned NUM_PATTERNS = 22;

    localparam t_pat_text PAT_TEXT [NUM_PATTERNS] = '{
        t_pat_text'("sytes"),
        t_pat_text'("instant"),
        t_pat_text'("dyndns"),
        t_pat_text'("no-ip"),
        t_pat_text'("http:"),
        t_pat_text'(".com"),
        t_pat_text'(".net"),
        t_pat_text'(".org"),
        t_pat_text'(".eu"),
        t_pat_text'(".fr"),
        t_pat_text'(".bg"),
        t_pat_text'(".info"),
        t_pat_text'(".br"),
        t_pat_text'("https:"),
        t_pat_text'("wow"),
        t_pat_text'("www."),
        t_pat_text'(".zapto"),
        t_pat_text'(".biz"),
        t_pat_text'(".servegame"),
        t_pat_text'(48'h6c696e656272),
        t_pat_text'(56'h617a72616c6f6e),
        t_pat_text'("ragn")
    };

    localparam int unsigned PAT_LEN [NUM_PATTERNS] = '{
        5, 7, 6, 5, 5, 4, 4, 4, 3, 3, 3, 5, 3, 6, 3, 4, 6, 4, 10, 6, 7, 4
    };

    function automatic t_pat_text pat_mask(input int unsigned len);
        t_pat_text m;
        m = '1;
        m = m >> (8 * (MAX_PATTERN_LEN - len));
        return m;
    endfunction

    // True when some pattern ends at the newest byte of the buffer.
    function automatic logic pattern_hit(input t_pat_text buf_bytes);
        logic hit;
        hit = 1'b0;
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            if (((buf_bytes ^ PAT_TEXT[p]) & pat_mask(PAT_LEN[p])) == '0) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

>>> rtl/ckf_fifo.sv
`timescale 1ns / 1ps

module ckf_fifo #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr, rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({wr, rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> rtl/ckf_front.sv
`timescale 1ns / 1ps

module ckf_front #(
    parameter int unsigned MID_DEPTH = ckf_pkg::MID_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  ckf_pkg::t_byte             i_char_byte,
    input  logic                       i_last_char,
    input  logic                       i_privileged,
    input  logic [ckf_pkg::LANG_W-1:0] i_language,
    input  logic                       i_pop,
    output ckf_pkg::t_mid_item         o_item,
    output logic                       o_empty
);

    ckf_pkg::t_mid_item item;
    logic               is_space;
    logic               is_upper;

    // Tab through carriage return, and the space character, are marked as not kept and never enter the window.
    assign is_space = ((i_char_byte >= ckf_pkg::CH_TAB) && (i_char_byte <= ckf_pkg::CH_CR))
                   || (i_char_byte == ckf_pkg::CH_SPACE);
    assign is_upper = (i_char_byte >= ckf_pkg::CH_UP_A) && (i_char_byte <= ckf_pkg::CH_UP_Z);

    always_comb begin
        item.ch   = is_upper ? (i_char_byte | ckf_pkg::CASE_BIT) : i_char_byte;
        item.keep = !is_space;
        item.last = i_last_char;
        item.priv = i_privileged;
        item.lang = i_language;
    end

    ckf_fifo #(
        .WIDTH ($bits(ckf_pkg::t_mid_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

endmodule

>>> rtl/ckf_back.sv
`timescale 1ns / 1ps

module ckf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ckf_pkg::LANG_W-1:0] i_addon_language,
    input  ckf_pkg::t_mid_item         i_item,
    input  logic                       i_empty,
    output logic                       o_pop,
    input  logic                       i_out_full,
    output ckf_pkg::t_verdict          o_verdict
);

    ckf_pkg::t_window r_win, n_win;
    logic             r_hit, n_hit;
    logic             match;
    logic             hit_now;

    assign o_pop   = !i_empty && !i_out_full;
    assign match   = ckf_pkg::pattern_hit({r_win, i_item.ch});
    assign hit_now = r_hit || (i_item.keep && match);

    always_comb begin
        n_win = r_win;
        n_hit = r_hit;
        if (o_pop) begin
            if (i_item.last) begin
                n_win = '0;
                n_hit = 1'b0;
            end else if (i_item.keep) begin
                n_win = {r_win[8*ckf_pkg::WIN_LEN-9:0], i_item.ch};
                n_hit = hit_now;
            end
        end
        o_verdict.push    = o_pop && i_item.last;
        o_verdict.blocked = hit_now && !i_item.priv && (i_item.lang != i_addon_language);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_hit <= 1'b0;
        end else begin
            r_win <= n_win;
            r_hit <= n_hit;
        end
    end

endmodule

>>> rtl/chat_keyword_filter.sv
`timescale 1ns / 1ps

// Channel     | Direction | Handshake            | Payload
// ------------+-----------+----------------------+-----------------------------------------
// byte in     | in        | push / full          | i_char_byte, i_last_char, i_privileged,
//             |           |                      | i_language
// verdict out | out       | empty / pop          | o_blocked
// config      | in        | i_cfg_we             | i_cfg_wdata (add-on language code)
//
// One byte request is taken every cycle while the byte queue has room. The last byte of a
// message waits in the byte queue until the result queue has room; the matcher's parallel
// pattern comparators then form the verdict combinationally and push it into the result
// queue, from which the consumer pops it.
// Reset is synchronous and active low; it empties both queues, clears the window and
// the hit flag, and sets the add-on language to all ones.
// A stalled result side only holds the matcher while its queue is full; the byte
// queue keeps taking requests until it fills as well.

module chat_keyword_filter #(
    parameter int unsigned MID_DEPTH = ckf_pkg::MID_QUEUE_DEPTH,
    parameter int unsigned OUT_DEPTH = ckf_pkg::OUT_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  ckf_pkg::t_byte             i_char_byte,
    input  logic                       i_last_char,
    input  logic                       i_privileged,
    input  logic [ckf_pkg::LANG_W-1:0] i_language,
    output logic                       empty,
    input  logic                       pop,
    output logic                       o_blocked,
    input  logic                       i_cfg_we,
    input  logic [ckf_pkg::LANG_W-1:0] i_cfg_wdata
);

    // Language code whose messages always pass.
    logic [ckf_pkg::LANG_W-1:0] r_addon_language;

    ckf_pkg::t_mid_item mid_item;
    logic               mid_empty;
    logic               mid_pop;
    logic               out_full;
    ckf_pkg::t_verdict  verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addon_language <= '1;
        end else if (i_cfg_we) begin
            r_addon_language <= i_cfg_wdata;
        end
    end

    // The front end folds case, marks whitespace and queues the request.
    ckf_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_char_byte  (i_char_byte),
        .i_last_char  (i_last_char),
        .i_privileged (i_privileged),
        .i_language   (i_language),
        .i_pop        (mid_pop),
        .o_item       (mid_item),
        .o_empty      (mid_empty)
    );

    // The back end shifts kept bytes through the window, runs the comparators
    // and forms the verdict on the last byte of each message.
    ckf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_addon_language (r_addon_language),
        .i_item           (mid_item),
        .i_empty          (mid_empty),
        .o_pop            (mid_pop),
        .i_out_full       (out_full),
        .o_verdict        (verdict)
    );

    // Verdicts wait here until the consumer pops them.
    ckf_fifo #(
        .WIDTH (1),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (verdict.push),
        .i_data  (verdict.blocked),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_blocked),
        .o_empty (empty)
    );

endmodule

>>> rtl/ckf_checker.sv
`timescale 1ns / 1ps

module ckf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input logic o_blocked
);

    // Reset leaves no result waiting and room for a new request.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // The input side can only fill up after a request was offered.
    a_full_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a request");

    // A waiting result that is not popped stays in place.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_blocked)))
        else $error("waiting result changed or vanished");

endmodule

bind chat_keyword_filter ckf_checker u_ckf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .o_blocked (o_blocked)
);
